// ----- hdl/dsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared types and constants for the DSF stereo deinterleaver.
// ----------------------------------------------------------------------------
package dsf_pkg;

    // Bytes in one channel block of a data group
    localparam int BLOCK_BYTES = 4096;
    localparam int BLK_AW      = $clog2(BLOCK_BYTES);
    localparam int BP_W        = $clog2(2 * BLOCK_BYTES);

    localparam int HPOS_W = 7;

    // Header byte offsets that complete a checked or loaded field
    localparam logic [HPOS_W-1:0] POS_DSD_ID   = 7'd3;
    localparam logic [HPOS_W-1:0] POS_DSD_SIZE = 7'd11;
    localparam logic [HPOS_W-1:0] POS_FMT_ID   = 7'd31;
    localparam logic [HPOS_W-1:0] POS_FMT_SIZE = 7'd39;
    localparam logic [HPOS_W-1:0] POS_VERSION  = 7'd43;
    localparam logic [HPOS_W-1:0] POS_FORMAT   = 7'd47;
    localparam logic [HPOS_W-1:0] POS_CH_TYPE  = 7'd51;
    localparam logic [HPOS_W-1:0] POS_CH_NUM   = 7'd55;
    localparam logic [HPOS_W-1:0] POS_RATE     = 7'd59;
    localparam logic [HPOS_W-1:0] POS_BITS     = 7'd63;
    localparam logic [HPOS_W-1:0] POS_SAMPLES  = 7'd71;
    localparam logic [HPOS_W-1:0] POS_BLOCK    = 7'd75;
    localparam logic [HPOS_W-1:0] POS_DATA_ID  = 7'd83;
    localparam logic [HPOS_W-1:0] POS_LAST     = 7'd91;

    localparam logic [31:0] ID_DSD      = 32'h2044_5344;
    localparam logic [31:0] ID_FMT      = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA     = 32'h6174_6164;
    localparam logic [31:0] DSD_RATE    = 32'd2822400;
    localparam logic [63:0] DSD_CK_SIZE = 64'd28;
    localparam logic [63:0] FMT_CK_SIZE = 64'd52;
    localparam logic [31:0] FMT_VERSION = 32'd1;
    localparam logic [31:0] FMT_RAW     = 32'd0;
    localparam logic [31:0] CH_STEREO   = 32'd2;
    localparam logic [31:0] BITS_LSB1ST = 32'd1;
    localparam logic [63:0] DATA_HDR_SZ = 64'd12;

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_DATA,
        MODE_DONE
    } t_mode;

    typedef enum logic [2:0] {
        ST_DATA      = 3'd0,
        ST_HDR_OK    = 3'd1,
        ST_BAD_ID    = 3'd2,
        ST_BAD_SIZE  = 3'd3,
        ST_BAD_FMT   = 3'd4,
        ST_BAD_BLOCK = 3'd5,
        ST_TOO_LARGE = 3'd6
    } t_status;

    // Header verdict for the byte under inspection; ST_DATA means no result
    typedef struct packed {
        t_status     status;
        logic        rev_load;
        logic        rev_val;
        logic        rem_load;
        logic [63:0] rem_val;
    } t_hdr_res;

    // One entry of the result register: a status or an L/R pair
    typedef struct packed {
        logic        is_pair;
        t_status     status;
        logic [7:0]  rb;
        logic        rev;
    } t_out_entry;

endpackage

// ----- hdl/dsf_stream_deinterleave.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_stream_deinterleave
// Stereo DSF stream: header check, then left/right block deinterleave.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  input     in         i_valid / o_stall      i_data_byte, i_first
//  result    out        o_valid / i_stall      o_out_byte, o_status, o_last
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (file size)
//
//  Header, left-block and ignored bytes leave the input register without waiting
//  on the result register, unless they yield a status. A right byte yields two
//  items (left then right) from the result register, so it waits until the
//  previous pair's right item is taken; the single result port sets the rate.
//  Reset is synchronous, active low; the left store needs no clearing pass.
//  A stalled result holds; input keeps flowing while it produces no items.
// ----------------------------------------------------------------------------
module dsf_stream_deinterleave import dsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    // result items
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic        o_last,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_first;

    // stream state
    t_mode            r_mode;
    t_mode            n_mode;
    logic [63:0]      r_remaining;
    logic [63:0]      n_remaining;
    logic             r_reverse;
    logic             n_reverse;
    logic [BP_W-1:0]  r_block_pos;
    logic [BP_W-1:0]  n_block_pos;
    logic [31:0]      r_file_size;

    t_mode            eff_mode;
    t_hdr_res         hdr;
    t_out_entry       entry;
    logic             blk_low;     // still filling the left block
    logic             needs_out;
    logic             out_free;
    logic             fire;
    logic             in_take;
    logic             hdr_step;
    logic [63:0]      rem_dec;
    logic [BP_W-1:0]  bp_inc;
    logic [7:0]       left_byte;
    logic             mem_wr;
    logic             mem_rd;
    logic [BLK_AW-1:0] rd_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= 32'hFFFF_FFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_file_size <= i_cfg_data;
        end
    end

    // ---- input register ----------------------------------------------------
    assign o_stall = r_in_valid && !fire;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first;
        end
    end

    // first marks a restart of header parsing with this very byte
    assign eff_mode = r_in_first ? MODE_HEADER : r_mode;
    assign blk_low  = (r_block_pos < BP_W'(BLOCK_BYTES));
    assign hdr_step = fire && (eff_mode == MODE_HEADER);

    dsf_hdr_parse u_hdr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (hdr_step),
        .i_restart   (r_in_first),
        .i_byte      (r_in_byte),
        .i_remaining (r_remaining),
        .i_file_size (r_file_size),
        .o_res       (hdr)
    );

    // ---- control outputs ---------------------------------------------------
    always_comb begin
        needs_out = 1'b0;
        unique case (eff_mode)
            MODE_HEADER: needs_out = (hdr.status != ST_DATA);
            MODE_DATA:   needs_out = !blk_low;
            MODE_DONE:   needs_out = 1'b0;
            default:     needs_out = 1'b0;
        endcase
        // items with no result never wait on the result register
        fire = r_in_valid && (!needs_out || out_free);
    end

    // ---- mode next state ---------------------------------------------------
    assign rem_dec = (r_remaining >= 64'd2) ? (r_remaining - 64'd2) : 64'd0;

    always_comb begin
        n_mode = r_mode;
        if (fire) begin
            unique case (eff_mode)
                MODE_HEADER: begin
                    if (hdr.status == ST_HDR_OK) begin
                        n_mode = (hdr.rem_val == 64'd0) ? MODE_DONE : MODE_DATA;
                    end else if (hdr.status != ST_DATA) begin
                        n_mode = MODE_DONE;
                    end else begin
                        n_mode = MODE_HEADER;
                    end
                end
                MODE_DATA: begin
                    if (!blk_low && rem_dec == 64'd0) begin
                        n_mode = MODE_DONE;
                    end
                end
                MODE_DONE: n_mode = MODE_DONE;
                default:   n_mode = r_mode;
            endcase
        end
    end

    // ---- datapath state ----------------------------------------------------
    assign bp_inc = (r_block_pos == BP_W'(2 * BLOCK_BYTES - 1))
                    ? '0 : r_block_pos + BP_W'(1);

    always_comb begin
        n_remaining = r_in_first ? 64'd0 : r_remaining;
        n_reverse   = r_in_first ? 1'b0  : r_reverse;
        n_block_pos = r_in_first ? '0    : r_block_pos;
        if (fire && eff_mode == MODE_HEADER) begin
            if (hdr.rem_load) begin
                n_remaining = hdr.rem_val;
            end
            if (hdr.rev_load) begin
                n_reverse = hdr.rev_val;
            end
            if (hdr.status == ST_HDR_OK) begin
                n_block_pos = '0;
            end
        end else if (fire && eff_mode == MODE_DATA) begin
            n_block_pos = bp_inc;
            if (!blk_low) begin
                n_remaining = rem_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HEADER;
            r_remaining <= '0;
            r_reverse   <= 1'b0;
            r_block_pos <= '0;
        end else if (fire) begin
            r_mode      <= n_mode;
            r_remaining <= n_remaining;
            r_reverse   <= n_reverse;
            r_block_pos <= n_block_pos;
        end
    end

    // ---- left store --------------------------------------------------------
    // right byte k reads left byte k of the same group
    assign mem_wr  = fire && (eff_mode == MODE_DATA) && blk_low;
    assign mem_rd  = fire && (eff_mode == MODE_DATA) && !blk_low;
    assign rd_addr = BLK_AW'(r_block_pos - BP_W'(BLOCK_BYTES));

    dsf_left_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_block_pos[BLK_AW-1:0]),
        .i_wr_data (r_in_byte),
        .i_rd_en   (mem_rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (left_byte)
    );

    // ---- result register ---------------------------------------------------
    always_comb begin
        entry.is_pair = (eff_mode == MODE_DATA);
        entry.status  = (eff_mode == MODE_HEADER) ? hdr.status : ST_DATA;
        entry.rb      = r_in_byte;
        entry.rev     = r_reverse;
    end

    dsf_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && needs_out),
        .i_entry    (entry),
        .i_left     (left_byte),
        .o_free     (out_free),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

// ----- hdl/dsf_hdr_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_hdr_parse
// Walks the 92-byte header, one byte per step, and checks or loads the fields it uses.
// ----------------------------------------------------------------------------
module dsf_hdr_parse import dsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_restart,
    input  logic [7:0]  i_byte,
    input  logic [63:0] i_remaining,
    input  logic [31:0] i_file_size,
    output t_hdr_res    o_res
);

    logic [HPOS_W-1:0] r_pos;
    logic [HPOS_W-1:0] n_pos;
    logic [63:0]       r_acc;
    logic [63:0]       n_acc;
    logic [HPOS_W-1:0] eff_pos;
    logic [63:0]       eff_acc;
    logic [31:0]       hi;
    logic [63:0]       body_size;
    logic [63:0]       rem_min;
    logic              too_large;

    assign eff_pos = i_restart ? '0 : r_pos;
    assign eff_acc = i_restart ? '0 : r_acc;
    assign n_acc   = {i_byte, eff_acc[63:8]};
    assign n_pos   = eff_pos + HPOS_W'(1);
    assign hi      = n_acc[63:32];

    // data chunk size less its own header, modulo 2^64
    assign body_size = n_acc - DATA_HDR_SZ;
    assign too_large = (body_size >= {32'd0, i_file_size});
    assign rem_min   = (body_size < i_remaining) ? body_size : i_remaining;

    always_comb begin
        o_res          = '0;
        o_res.status   = ST_DATA;
        o_res.rev_val  = (hi == BITS_LSB1ST);
        o_res.rem_val  = {2'b00, n_acc[63:2]};
        unique case (eff_pos)
            POS_DSD_ID:   if (hi != ID_DSD)        o_res.status = ST_BAD_ID;
            POS_DSD_SIZE: if (n_acc != DSD_CK_SIZE) o_res.status = ST_BAD_SIZE;
            POS_FMT_ID:   if (hi != ID_FMT)        o_res.status = ST_BAD_ID;
            POS_FMT_SIZE: if (n_acc != FMT_CK_SIZE) o_res.status = ST_BAD_SIZE;
            POS_VERSION:  if (hi != FMT_VERSION)   o_res.status = ST_BAD_FMT;
            POS_FORMAT:   if (hi != FMT_RAW)       o_res.status = ST_BAD_FMT;
            POS_CH_TYPE:  if (hi != CH_STEREO)     o_res.status = ST_BAD_FMT;
            POS_CH_NUM:   if (hi != CH_STEREO)     o_res.status = ST_BAD_FMT;
            POS_RATE:     if (hi != DSD_RATE)      o_res.status = ST_BAD_FMT;
            POS_BITS:     o_res.rev_load = 1'b1;
            POS_SAMPLES:  o_res.rem_load = 1'b1;
            POS_BLOCK:    if (hi != 32'(BLOCK_BYTES)) o_res.status = ST_BAD_BLOCK;
            POS_DATA_ID:  if (hi != ID_DATA)       o_res.status = ST_BAD_ID;
            POS_LAST: begin
                if (too_large) begin
                    o_res.status = ST_TOO_LARGE;
                end else begin
                    o_res.status   = ST_HDR_OK;
                    o_res.rem_load = 1'b1;
                    o_res.rem_val  = {rem_min[63:2], 2'b00};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_acc <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_acc <= n_acc;
        end
    end

endmodule

// ----- hdl/dsf_left_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_left_store
// Left-channel block memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dsf_left_store import dsf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [BLK_AW-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [BLK_AW-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [BLOCK_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/dsf_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_out_stage
// Result register: sends a status item, or a left/right pair as two items.
// ----------------------------------------------------------------------------
module dsf_out_stage import dsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_out_entry i_entry,
    input  logic [7:0] i_left,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_last
);

    logic       r_valid;
    logic       r_half;
    t_out_entry r_entry;
    logic       cur_last;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = b[i];
        end
        return r;
    endfunction

    assign cur_last = !r_entry.is_pair || r_half;
    assign o_free   = !r_valid || (!i_stall && cur_last);
    assign o_valid  = r_valid;

    always_comb begin
        if (!r_entry.is_pair) begin
            o_out_byte = 8'd0;
            o_status   = r_entry.status;
            o_last     = 1'b1;
        end else if (!r_half) begin
            o_out_byte = r_entry.rev ? rev8(i_left) : i_left;
            o_status   = ST_DATA;
            o_last     = 1'b0;
        end else begin
            o_out_byte = r_entry.rev ? rev8(r_entry.rb) : r_entry.rb;
            o_status   = ST_DATA;
            o_last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_half  <= 1'b0;
        end else if (r_valid && !i_stall) begin
            if (cur_last) begin
                r_valid <= 1'b0;
            end else begin
                r_half <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_entry;
        end
    end

endmodule

// ----- hdl/dsf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dsf_checker import dsf_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic [2:0]  o_status,
    input logic        o_last
);

    // a status item is always alone
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_DATA) |-> o_last)
        else $error("status item without last");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_DATA) |-> (o_out_byte == 8'd0))
        else $error("status item with non-zero byte");

    // a taken left byte is followed at once by its right byte
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_status == ST_DATA && !o_last)
        |=> (o_valid && o_status == ST_DATA && o_last))
        else $error("left byte not followed by right byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_byte)
                                  && $stable(o_status) && $stable(o_last)))
        else $error("stalled item changed");

endmodule

bind dsf_stream_deinterleave dsf_checker u_dsf_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DSF stereo deinterleaver. A table of whole-file
// cases covers every header check, the data size limits and the payload
// corner cases, then random files run under several file size settings. Each
// result item is compared with an in-bench model of the parser or, in typed rows, with the table.
// ----------------------------------------------------------------------------
module testbench;
    import dsf_pkg::*;

    localparam int HDR_BYTES     = int'(POS_LAST) + 1;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;     // lets trailing header/left bytes clear
    localparam int WD_LIMIT      = 2000;  // cycles with no handshake at all

    // one result item as seen on the output port
    typedef struct packed {
        logic [7:0] smp;
        t_status    st;
        logic       last;
    } t_dsf_res;

    // one directed file: a header, optionally corrupted, then data bytes
    typedef struct {
        int          mut_pos;     // header byte overwritten, -1 for none
        logic [7:0]  mut_val;
        logic [31:0] bits;
        logic [63:0] samples;
        logic [63:0] data_ck;     // data chunk size field
        int          n_hdr;       // header bytes sent (short = truncated file)
        int          n_data;      // bytes sent after the header
        bit          lead_first;  // first flag on header byte 0
        bit          typed;       // status typed in below, model muted
        t_status     exp_st;
        bit          squeeze;     // long receiver hold at first right byte
    } t_dsf_case;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time 0
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_first     = 1'b0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_status;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data  = 32'h0000_0000;

    dsf_stream_deinterleave dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_first     (i_first),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model state: own copy, updated as each item is offered
    // ------------------------------------------------------------------------
    logic [31:0] m_fsize;
    t_mode       m_mode;
    logic [6:0]  m_hpos;
    logic [63:0] m_acc;       // last eight header bytes, little-endian
    logic [63:0] m_dsize;
    logic [63:0] m_remain;    // payload bytes still to emit
    logic        m_rev;
    int          m_bpos;      // position within the current L+R group
    logic [7:0]  m_left [BLOCK_BYTES];
    bit          m_mute;      // typed rows push their own expectation

    t_dsf_res    pending_out [$];  // expected result items, oldest first
    int          n_fail = 0;

    logic [7:0]  hdr_buf [HDR_BYTES];
    bit          idle_on  = 1'b1;
    bit          hold_req = 1'b0;
    int          data_files_left = 3;
    int          quiet_cycles = 0;

    function automatic logic [7:0] bitrev8(input logic [7:0] v);
        for (int i = 0; i < 8; i++) bitrev8[i] = v[7 - i];
    endfunction

    // everything bar the register and the left store
    function automatic void parser_restart();
        m_mode   = MODE_HEADER;
        m_hpos   = '0;
        m_acc    = '0;
        m_dsize  = '0;
        m_remain = '0;
        m_rev    = 1'b0;
        m_bpos   = 0;
    endfunction

    function automatic void expect_res(logic [7:0] smp, t_status st, logic last);
        t_dsf_res r;
        r.smp  = smp;
        r.st   = st;
        r.last = last;
        pending_out.push_back(r);
    endfunction

    // Predict the result items of one input item
    function automatic void deinterleave_step(logic [7:0] b, logic f);
        logic [6:0]  pos;
        logic [31:0] hi;
        t_status     st;
        logic [7:0]  lb;
        logic [7:0]  rb;
        if (f) parser_restart();
        case (m_mode)
            MODE_HEADER: begin
                m_acc  = {b, m_acc[63:8]};
                pos    = m_hpos;
                m_hpos = m_hpos + 7'd1;
                hi     = m_acc[63:32];
                st     = ST_DATA;
                case (pos)
                    POS_DSD_ID:   if (hi != ID_DSD) st = ST_BAD_ID;
                    POS_DSD_SIZE: if (m_acc != DSD_CK_SIZE) st = ST_BAD_SIZE;
                    POS_FMT_ID:   if (hi != ID_FMT) st = ST_BAD_ID;
                    POS_FMT_SIZE: if (m_acc != FMT_CK_SIZE) st = ST_BAD_SIZE;
                    POS_VERSION:  if (hi != FMT_VERSION) st = ST_BAD_FMT;
                    POS_FORMAT:   if (hi != FMT_RAW) st = ST_BAD_FMT;
                    POS_CH_TYPE:  if (hi != CH_STEREO) st = ST_BAD_FMT;
                    POS_CH_NUM:   if (hi != CH_STEREO) st = ST_BAD_FMT;
                    POS_RATE:     if (hi != DSD_RATE) st = ST_BAD_FMT;
                    POS_BITS:     m_rev = (hi == BITS_LSB1ST);
                    POS_SAMPLES:  m_remain = m_acc >> 2;
                    POS_BLOCK:    if (hi != 32'(BLOCK_BYTES)) st = ST_BAD_BLOCK;
                    POS_DATA_ID:  if (hi != ID_DATA) st = ST_BAD_ID;
                    POS_LAST: begin
                        m_dsize = m_acc - DATA_HDR_SZ;   // wraps below 12
                        if (m_dsize >= 64'(m_fsize)) begin
                            st = ST_TOO_LARGE;
                        end else begin
                            if (m_dsize < m_remain) m_remain = m_dsize;
                            m_remain[1:0] = 2'b00;
                            m_bpos = 0;
                            st = ST_HDR_OK;
                        end
                    end
                    default: ;
                endcase
                if (st != ST_DATA) begin
                    if (st == ST_HDR_OK && m_remain != 0) m_mode = MODE_DATA;
                    else m_mode = MODE_DONE;
                    if (!m_mute) expect_res(8'h00, st, 1'b1);
                end
            end
            MODE_DATA: begin
                if (m_bpos < BLOCK_BYTES) begin
                    m_left[m_bpos] = b;
                    m_bpos++;
                end else begin
                    // right byte k pairs with left byte k of this group
                    lb = m_left[m_bpos - BLOCK_BYTES];
                    rb = b;
                    if (m_rev) begin
                        lb = bitrev8(lb);
                        rb = bitrev8(rb);
                    end
                    if (!m_mute) begin
                        expect_res(lb, ST_DATA, 1'b0);
                        expect_res(rb, ST_DATA, 1'b1);
                    end
                    m_bpos++;
                    if (m_bpos >= 2 * BLOCK_BYTES) m_bpos = 0;
                    m_remain = (m_remain >= 2) ? m_remain - 64'd2 : 64'd0;
                    if (m_remain == 0) m_mode = MODE_DONE;
                end
            end
            default: ;  // done: ignore until first
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Header image
    // ------------------------------------------------------------------------
    function automatic void put_le(int at, logic [63:0] v, int n);
        for (int i = 0; i < n; i++) hdr_buf[at + i] = v[8 * i +: 8];
    endfunction

    // well-formed header; unchecked fields get random content
    function automatic void build_header(logic [31:0] bits, logic [63:0] samples,
                                         logic [63:0] data_ck);
        put_le(0,  64'(ID_DSD), 4);
        put_le(4,  DSD_CK_SIZE, 8);
        put_le(12, {$urandom, $urandom}, 8);   // file size field, not checked
        put_le(20, {$urandom, $urandom}, 8);   // metadata pointer
        put_le(28, 64'(ID_FMT), 4);
        put_le(32, FMT_CK_SIZE, 8);
        put_le(40, 64'(FMT_VERSION), 4);
        put_le(44, 64'(FMT_RAW), 4);
        put_le(48, 64'(CH_STEREO), 4);
        put_le(52, 64'(CH_STEREO), 4);
        put_le(56, 64'(DSD_RATE), 4);
        put_le(60, 64'(bits), 4);
        put_le(64, samples, 8);
        put_le(72, 64'(BLOCK_BYTES), 4);
        put_le(76, 64'($urandom), 4);          // reserved
        put_le(80, 64'(ID_DATA), 4);
        put_le(84, data_ck, 8);
    endfunction

    function automatic t_dsf_case mk_case(int mut_pos, logic [7:0] mut_val,
                                          logic [31:0] bits, logic [63:0] samples,
                                          logic [63:0] data_ck, int n_hdr, int n_data,
                                          bit lead_first, bit typed, t_status exp_st,
                                          bit squeeze);
        t_dsf_case c;
        c.mut_pos    = mut_pos;
        c.mut_val    = mut_val;
        c.bits       = bits;
        c.samples    = samples;
        c.data_ck    = data_ck;
        c.n_hdr      = n_hdr;
        c.n_data     = n_data;
        c.lead_first = lead_first;
        c.typed      = typed;
        c.exp_st     = exp_st;
        c.squeeze    = squeeze;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: optional idle gap, then hold the item until taken.
    // Called at a rising edge; the model sees the item as it is offered.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic f);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        deinterleave_step(b, f);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_first     <= f;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Quiet the input side, let all expected items drain, then wait SETTLE_CYCLES
    // more since trailing header/left bytes give no result to wait on.
    task automatic drain_block();
        i_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_file_size(input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        m_fsize = v;
    endtask

    // One random file. Mostly well-formed headers; some corrupted, truncated
    // or plain noise. Data only for a few files, since each costs a block.
    task automatic send_random_file();
        int          kind;
        int          n;
        int          rights;
        int          total;
        logic [63:0] dsize;
        logic [63:0] samples;
        logic [31:0] bits;
        kind = $urandom_range(0, 19);
        if (kind >= 18) begin
            n = $urandom_range(1, 20);
            repeat (n) send_item(8'($urandom), $urandom_range(0, 7) == 0);
            return;
        end
        case ($urandom_range(0, 3))
            0:       dsize = (m_fsize == 0) ? 64'd0 : 64'(m_fsize) - 64'd1;  // just fits
            1:       dsize = 64'(m_fsize);                                  // just too big
            2:       dsize = 64'($urandom_range(0, 300));
            default: dsize = {$urandom, $urandom};
        endcase
        samples = $urandom_range(0, 1) ? 64'($urandom_range(0, 1200)) : {$urandom, $urandom};
        if (!(data_files_left > 0 && $urandom_range(0, 2) == 0))
            samples = 64'($urandom_range(0, 3));              // zero payload
        else if (dsize > 64'd1200 && samples > 64'd4800)
            samples = 64'($urandom_range(0, 4800));           // keep payload short
        if ($urandom_range(0, 1)) bits = BITS_LSB1ST;
        else bits = ($urandom_range(0, 3) == 0) ? $urandom : 32'd8;
        build_header(bits, samples, dsize + DATA_HDR_SZ);
        if (kind >= 14) hdr_buf[$urandom_range(0, HDR_BYTES - 1)] = 8'($urandom);
        n = (kind >= 12 && kind < 14) ? $urandom_range(1, HDR_BYTES - 1) : HDR_BYTES;
        for (int i = 0; i < n; i++) send_item(hdr_buf[i], i == 0);
        if (n != HDR_BYTES) return;                 // next file restarts it
        if (m_mode == MODE_DATA && data_files_left > 0) begin
            data_files_left--;
            rights = (m_remain > 64'd1400) ? 700 : int'(m_remain >> 1);
            if (m_remain > 64'd1400 || $urandom_range(0, 5) == 0)
                total = $urandom_range(1, BLOCK_BYTES + rights - 1);   // cut short
            else
                total = BLOCK_BYTES + rights + $urandom_range(0, 4);   // trailing bytes
            repeat (total) send_item(8'($urandom), 1'b0);
        end else begin
            repeat ($urandom_range(0, 6)) send_item(8'($urandom), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver pacing: short stall bursts, plus one long hold on request so
    // that the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial begin : rx_pace
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check against the oldest expectation
    // ------------------------------------------------------------------------
    t_dsf_res head;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_out.size() == 0) begin
                $error("result with nothing pending: out_byte %0h status %0d last %0b",
                       o_out_byte, o_status, o_last);
                n_fail++;
            end else begin
                head = pending_out.pop_front();
                if (o_out_byte !== head.smp) begin
                    $error("out_byte expected %0h got %0h", head.smp, o_out_byte);
                    n_fail++;
                end
                if (o_status !== head.st) begin
                    $error("status expected %0d got %0d", head.st, o_status);
                    n_fail++;
                end
                if (o_last !== head.last) begin
                    $error("last expected %0b got %0b", head.last, o_last);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: no handshake of any kind for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    t_dsf_case dir_tab [$];

    initial begin : main_seq
        t_dsf_case   dc;
        int          exp_at;
        logic [31:0] fsize_set [6];

        m_fsize = 32'hFFFF_FFFF;
        m_mute  = 1'b0;
        parser_restart();

        // mut  val    bits         samples       data_ck     hdr        data
        //     lead  typed  status     squeeze
        // after reset, byte 0 without first: zero payload
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd8, 64'd0, 64'd112, HDR_BYTES, 3,
                                  1'b0, 1'b1, ST_HDR_OK, 1'b0));
        // each check, tripped on the byte that completes its field
        dir_tab.push_back(mk_case(int'(POS_DSD_ID), 8'h21, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_ID, 1'b0));
        dir_tab.push_back(mk_case(int'(POS_DSD_SIZE), 8'hFF, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_SIZE, 1'b0));
        dir_tab.push_back(mk_case(int'(POS_FMT_ID), 8'h00, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_ID, 1'b0));
        dir_tab.push_back(mk_case(int'(POS_FMT_SIZE), 8'h80, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_SIZE, 1'b0));
        dir_tab.push_back(mk_case(int'(POS_VERSION), 8'h01, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_FMT, 1'b0));
        dir_tab.push_back(mk_case(int'(POS_FORMAT), 8'hFF, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_FMT, 1'b0));
        dir_tab.push_back(mk_case(int'(POS_CH_TYPE), 8'h01, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_FMT, 1'b0));
        dir_tab.push_back(mk_case(int'(POS_CH_NUM), 8'h80, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_FMT, 1'b0));
        dir_tab.push_back(mk_case(int'(POS_RATE), 8'hFF, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_FMT, 1'b0));
        dir_tab.push_back(mk_case(int'(POS_BLOCK), 8'h01, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_BLOCK, 1'b0));
        dir_tab.push_back(mk_case(int'(POS_DATA_ID), 8'h00, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_BAD_ID, 1'b0));
        // chunk size below 12 wraps to a huge data size; all-ones likewise
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd8, 64'd0, 64'd0,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_TOO_LARGE, 1'b0));
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd8, 64'd0, '1,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_TOO_LARGE, 1'b0));
        // zero data size with every sample present: zero payload, rest ignored
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd1, '1, 64'd12,
                                  HDR_BYTES, 4, 1'b1, 1'b1, ST_HDR_OK, 1'b0));
        // data size one under the limit, then exactly at it
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd8, 64'd3, 64'h1_0000_000A,
                                  HDR_BYTES, 2, 1'b1, 1'b1, ST_HDR_OK, 1'b0));
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd8, 64'd3, 64'h1_0000_000B,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_TOO_LARGE, 1'b0));
        // header cut short; the next file restarts it
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd8, 64'd0, 64'd112,
                                  40, 0, 1'b1, 1'b0, ST_DATA, 1'b0));
        // bit reversal, payload from the sample count rounded down, trailing bytes
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd1, 64'd43, 64'd112,
                                  HDR_BYTES, BLOCK_BYTES + 4 + 3, 1'b1, 1'b0, ST_DATA, 1'b0));
        // payload from data size, runs into a short second group; long hold
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd8, '1, 64'd8210,
                                  HDR_BYTES, 3 * BLOCK_BYTES + 4, 1'b1, 1'b0, ST_DATA, 1'b1));
        // restart in the middle of the left block, then of the right block
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd1, 64'd4000, 64'd1012,
                                  HDR_BYTES, 2000, 1'b1, 1'b0, ST_DATA, 1'b0));
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd8, '1, 64'd28,
                                  HDR_BYTES, BLOCK_BYTES + 3, 1'b1, 1'b0, ST_DATA, 1'b0));
        dir_tab.push_back(mk_case(-1, 8'h00, 32'd8, 64'd0, 64'd112,
                                  HDR_BYTES, 0, 1'b1, 1'b1, ST_HDR_OK, 1'b0));

        fsize_set[0] = 32'd0;            // nothing fits
        fsize_set[1] = 32'd8000;
        fsize_set[2] = $urandom;
        fsize_set[3] = 32'hFFFF_FFFF;
        fsize_set[4] = 32'd200;
        fsize_set[5] = $urandom;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed files, register at its reset value
        foreach (dir_tab[r]) begin
            dc     = dir_tab[r];
            build_header(dc.bits, dc.samples, dc.data_ck);
            if (dc.mut_pos >= 0) hdr_buf[dc.mut_pos] = dc.mut_val;
            exp_at = (dc.mut_pos >= 0) ? dc.mut_pos : HDR_BYTES - 1;
            m_mute = dc.typed;
            for (int i = 0; i < dc.n_hdr; i++) begin
                if (dc.typed && i == exp_at) expect_res(8'h00, dc.exp_st, 1'b1);
                send_item(hdr_buf[i], (i == 0) ? dc.lead_first : 1'b0);
            end
            m_mute = 1'b0;
            for (int i = 0; i < dc.n_data; i++) begin
                if (dc.squeeze && i == BLOCK_BYTES) hold_req = 1'b1;
                send_item(8'($urandom), 1'b0);
            end
        end

        // random files, one register setting per phase; third and last phases run flat out
        for (int ph = 0; ph < 6; ph++) begin
            drain_block();
            write_file_size(fsize_set[ph]);
            idle_on = (ph != 2 && ph != 5);
            repeat (8) send_random_file();
        end

        drain_block();
        if (pending_out.size() != 0) begin
            $error("%0d expected result items never arrived", pending_out.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dsf_pkg.sv
hdl/dsf_hdr_parse.sv
hdl/dsf_left_store.sv
hdl/dsf_out_stage.sv
hdl/dsf_stream_deinterleave.sv
hdl/dsf_checker.sv
tb/testbench.sv
